FILE: rtl/bfts_pkg.sv
`default_nettype none

package bfts_pkg;

  localparam int CNT_W     = 17;
  localparam int KEY_W     = 32;
  localparam int MAX_ITEMS = 65536;

  // tp + fp + P needs two bits more than one count.
  localparam int SUM_W  = CNT_W + 2;
  localparam int PROD_W = CNT_W + SUM_W;

  // Counts saturate at the smaller of MAX_ITEMS and the largest count code.
  localparam logic [CNT_W-1:0] CNT_CAP =
    (MAX_ITEMS < (2**CNT_W - 1)) ? CNT_W'(MAX_ITEMS) : {CNT_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
  } score_t;

endpackage

`default_nettype wire

FILE: rtl/best_f1_threshold_scan.sv
// Channel   Handshake                      Payload
// config    positive_total_we              positive_total
// item      item_valid / item_stall        sort_key, label_positive, last_item
// result    result_valid / result_stall    best_key, best_true_pos, best_false_pos,
//                                          found_better
//
// One request is taken every cycle while item_stall is low; a result is registered
// after the request carrying last_item passes the scan stage, then the final compare.
// The scan stage holds one cross-multiply compare per cycle for the group that
// closes on a key change; the group closed by last_item is scored in the next stage.
// item_stall rises only when a last_item request waits behind a full final stage.
// rst is synchronous and clears all run state and positive_total.
`default_nettype none

module best_f1_threshold_scan
  import bfts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             positive_total_we,
  input  logic [CNT_W-1:0] positive_total,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [KEY_W-1:0] sort_key,
  input  logic             label_positive,
  input  logic             last_item,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [KEY_W-1:0] best_key,
  output logic [CNT_W-1:0] best_true_pos,
  output logic [CNT_W-1:0] best_false_pos,
  output logic             found_better
);

  logic [CNT_W-1:0] p_total;

  logic             s1_valid;
  logic [KEY_W-1:0] s1_key;
  logic             s1_pos;
  logic             s1_last;

  logic [CNT_W-1:0] tp_cnt;
  logic [CNT_W-1:0] fp_cnt;
  logic [KEY_W-1:0] prev_key;
  logic             have_prev;
  score_t           best_sc;
  logic [KEY_W-1:0] best_key_r;
  logic             best_found;

  logic             s2_valid;
  score_t           s2_cand;
  logic [KEY_W-1:0] s2_key;
  score_t           s2_best;
  logic [KEY_W-1:0] s2_best_key;
  logic             s2_found;

  logic             s2_go;
  logic             s2_free;
  logic             s1_go;
  logic             close_a;
  logic             a_better;
  logic             take_a;
  logic             b_better;
  score_t           cur_sc;
  score_t           best_a_sc;
  logic [KEY_W-1:0] best_a_key;
  logic             best_a_found;
  logic [CNT_W-1:0] tp_next;
  logic [CNT_W-1:0] fp_next;

  assign s2_go      = !result_valid || !result_stall;
  assign s2_free    = !s2_valid || s2_go;
  assign s1_go      = s1_valid && (!s1_last || s2_free);
  assign item_stall = s1_valid && s1_last && !s2_free;

  // A change of key closes the previous group with the counts held so far.
  assign close_a = have_prev && (s1_key != prev_key);
  assign cur_sc  = '{tp: tp_cnt, fp: fp_cnt};

  bfts_better u_close (
    .cand   (cur_sc),
    .best   (best_sc),
    .found  (best_found),
    .total  (p_total),
    .better (a_better)
  );

  assign take_a       = close_a && a_better;
  assign best_a_sc    = take_a ? cur_sc : best_sc;
  assign best_a_key   = take_a ? prev_key : best_key_r;
  assign best_a_found = best_found || take_a;

  assign tp_next = (s1_pos && (tp_cnt != CNT_CAP)) ? tp_cnt + 1'b1 : tp_cnt;
  assign fp_next = (!s1_pos && (fp_cnt != CNT_CAP)) ? fp_cnt + 1'b1 : fp_cnt;

  // The group that contains the last item is scored here, against the best
  // carried over from the scan stage.
  bfts_better u_final (
    .cand   (s2_cand),
    .best   (s2_best),
    .found  (s2_found),
    .total  (p_total),
    .better (b_better)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_total      <= '0;
      s1_valid     <= 1'b0;
      tp_cnt       <= '0;
      fp_cnt       <= '0;
      prev_key     <= '0;
      have_prev    <= 1'b0;
      best_sc      <= '0;
      best_key_r   <= '0;
      best_found   <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (positive_total_we) begin
        p_total <= positive_total;
      end

      if (item_valid && !item_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_last) begin
          tp_cnt     <= '0;
          fp_cnt     <= '0;
          prev_key   <= '0;
          have_prev  <= 1'b0;
          best_sc    <= '0;
          best_key_r <= '0;
          best_found <= 1'b0;
        end else begin
          tp_cnt     <= tp_next;
          fp_cnt     <= fp_next;
          prev_key   <= s1_key;
          have_prev  <= 1'b1;
          best_sc    <= best_a_sc;
          best_key_r <= best_a_key;
          best_found <= best_a_found;
        end
      end

      if (s1_go && s1_last) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end

      if (s2_go) begin
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_key  <= sort_key;
      s1_pos  <= label_positive;
      s1_last <= last_item;
    end

    if (s1_go && s1_last) begin
      s2_cand     <= '{tp: tp_next, fp: fp_next};
      s2_key      <= s1_key;
      s2_best     <= best_a_sc;
      s2_best_key <= best_a_key;
      s2_found    <= best_a_found;
    end

    if (s2_go && s2_valid) begin
      if (b_better) begin
        best_key       <= s2_key;
        best_true_pos  <= s2_cand.tp;
        best_false_pos <= s2_cand.fp;
        found_better   <= 1'b1;
      end else begin
        best_key       <= s2_best_key;
        best_true_pos  <= s2_best.tp;
        best_false_pos <= s2_best.fp;
        found_better   <= s2_found;
      end
    end
  end

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_last && s2_valid))
    else $error("item stall without a waiting last request");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (tp_cnt <= CNT_CAP) && (fp_cnt <= CNT_CAP))
    else $error("count beyond saturation cap");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (!have_prev && !best_found && tp_cnt == '0 && fp_cnt == '0))
    else $error("run state not cleared after last request");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found_better) |->
      (best_key == '0 && best_true_pos == '0 && best_false_pos == '0))
    else $error("result without a scoring group is not zero");

  a_found_has_tp: assert property (@(posedge clk) disable iff (rst)
    best_found |-> (best_sc.tp != '0))
    else $error("held best has no true positives");

endmodule

`default_nettype wire

FILE: rtl/bfts_better.sv
`default_nettype none

// Exact F-measure compare: cand.tp/(cand.tp+cand.fp+P) > best.tp/(best.tp+best.fp+P),
// done by cross-multiplication. A candidate with no true positives scores zero
// and never wins; the first scoring candidate wins when nothing is held yet.
module bfts_better
  import bfts_pkg::*;
(
  input  score_t           cand,
  input  score_t           best,
  input  logic             found,
  input  logic [CNT_W-1:0] total,
  output logic             better
);

  logic [SUM_W-1:0]  cand_den;
  logic [SUM_W-1:0]  best_den;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  assign cand_den = SUM_W'(cand.tp) + SUM_W'(cand.fp) + SUM_W'(total);
  assign best_den = SUM_W'(best.tp) + SUM_W'(best.fp) + SUM_W'(total);

  assign lhs = {{SUM_W{1'b0}}, cand.tp} * {{CNT_W{1'b0}}, best_den};
  assign rhs = {{SUM_W{1'b0}}, best.tp} * {{CNT_W{1'b0}}, cand_den};

  assign better = (cand.tp != '0) && (!found || (lhs > rhs));

endmodule

`default_nettype wire

FILE: sim/best_f1_threshold_scan_tb.sv
module best_f1_threshold_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfts_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PART_ITEMS   = 120;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             positive;
    logic             last;
  } scan_request_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] fp;
    logic             found;
  } best_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             positive_total_we = 1'b0;
  logic [CNT_W-1:0] positive_total = '0;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic [KEY_W-1:0] sort_key = '0;
  logic             label_positive = 1'b0;
  logic             last_item = 1'b0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [KEY_W-1:0] best_key;
  logic [CNT_W-1:0] best_true_pos;
  logic [CNT_W-1:0] best_false_pos;
  logic             found_better;

  best_f1_threshold_scan dut (.*);

  initial forever #4 clk = ~clk;

  scan_request_t pending_requests[$];
  best_result_t  expected_best[$];

  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int results_found = 0;
  int input_stall_cycles = 0;
  int errors = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 75;
  bit hold_go = 1'b0;

  // Shadow state of the scan: running counts, open group and best so far.
  logic [CNT_W-1:0] cfg_positives = '0;
  logic [CNT_W-1:0] run_tp = '0;
  logic [CNT_W-1:0] run_fp = '0;
  logic [KEY_W-1:0] open_key = '0;
  logic             open_valid = 1'b0;
  logic [CNT_W-1:0] top_tp = '0;
  logic [CNT_W-1:0] top_fp = '0;
  logic [KEY_W-1:0] top_key = '0;
  logic             top_found = 1'b0;

  // Scores 2tp/(tp+fp+P) are compared exactly: tp*best_den > best_tp*den.
  function automatic void score_group(input logic [KEY_W-1:0] key);
    logic [63:0] den, top_den;
    den = 64'(run_tp) + 64'(run_fp) + 64'(cfg_positives);
    top_den = 64'(top_tp) + 64'(top_fp) + 64'(cfg_positives);
    if (run_tp == '0 || den == 0) return;
    if (!top_found || 64'(run_tp) * top_den > 64'(top_tp) * den) begin
      top_tp = run_tp;
      top_fp = run_fp;
      top_key = key;
      top_found = 1'b1;
    end
  endfunction

  function automatic void scan_request(input scan_request_t req);
    best_result_t res;
    if (open_valid && req.key != open_key) score_group(open_key);
    if (req.positive) run_tp = (run_tp < CNT_CAP) ? run_tp + 1'b1 : CNT_CAP;
    else run_fp = (run_fp < CNT_CAP) ? run_fp + 1'b1 : CNT_CAP;
    open_key = req.key;
    open_valid = 1'b1;
    if (req.last) begin
      score_group(req.key);
      res.key = top_key;
      res.tp = top_tp;
      res.fp = top_fp;
      res.found = top_found;
      expected_best.push_back(res);
      run_tp = '0;
      run_fp = '0;
      open_key = '0;
      open_valid = 1'b0;
      top_tp = '0;
      top_fp = '0;
      top_key = '0;
      top_found = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    scan_request_t req;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_stall) input_stall_cycles++;
      if (item_valid && !item_stall) begin
        req.key = sort_key;
        req.positive = label_positive;
        req.last = last_item;
        scan_request(req);
        items_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          item_valid <= 1'b1;
          sort_key <= req.key;
          label_positive <= req.positive;
          last_item <= req.last;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    best_result_t want;
    bit hold_seen;
    int hold_left;
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (!rst && result_valid && !result_stall) begin
      if (expected_best.size() == 0) begin
        $error("result with no request awaiting one: key %h tp %0d fp %0d found %0b",
               best_key, best_true_pos, best_false_pos, found_better);
        errors++;
      end else begin
        want = expected_best.pop_front();
        results_checked++;
        if (want.found) results_found++;
        if (best_key !== want.key) begin
          $error("best_key expected %h actual %h", want.key, best_key);
          errors++;
        end
        if (best_true_pos !== want.tp) begin
          $error("best_true_pos expected %0d actual %0d", want.tp, best_true_pos);
          errors++;
        end
        if (best_false_pos !== want.fp) begin
          $error("best_false_pos expected %0d actual %0d", want.fp, best_false_pos);
          errors++;
        end
        if (found_better !== want.found) begin
          $error("found_better expected %0b actual %0b", want.found, found_better);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic add_item(input logic [KEY_W-1:0] key, input logic positive,
                          input logic last);
    scan_request_t req;
    req.key = key;
    req.positive = positive;
    req.last = last;
    pending_requests.push_back(req);
    items_queued++;
  endtask

  // Mostly ascending keys with repeated groups; scrambled runs revisit a few
  // small keys out of order.
  task automatic add_random_run(input int run_len, input bit scrambled);
    logic [KEY_W-1:0] key;
    int pos_pct;
    key = $urandom;
    pos_pct = $urandom_range(0, 100);
    for (int i = 0; i < run_len; i++) begin
      if (scrambled) begin
        key = ($urandom_range(0, 1) != 0) ? $urandom : KEY_W'($urandom_range(0, 3));
      end else if (i > 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: ;
          9: key = key + ($urandom >> $urandom_range(0, 31));
          default: key = key + $urandom_range(1, 1000);
        endcase
      end
      add_item(key, $urandom_range(0, 99) < pos_pct, i == run_len - 1);
    end
  endtask

  task automatic write_positive_total(input logic [CNT_W-1:0] value);
    @(posedge clk);
    positive_total_we <= 1'b1;
    positive_total <= value;
    @(posedge clk);
    positive_total_we <= 1'b0;
    cfg_positives = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || expected_best.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int part_start;
    logic [CNT_W-1:0] p_value;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_positive_total('0);
    add_item(32'h0000_0000, 1'b0, 1'b1);
    add_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    // With P = 0 and only positives every group scores the same; the first wins.
    add_item(32'h0000_0001, 1'b1, 1'b0);
    add_item(32'h0000_0002, 1'b1, 1'b0);
    add_item(32'h0000_0003, 1'b1, 1'b1);
    wait_drained();

    write_positive_total(CNT_W'(65536));
    add_item(32'h0000_0005, 1'b1, 1'b0);
    add_item(32'h0000_0005, 1'b1, 1'b0);
    add_item(32'h0000_0007, 1'b0, 1'b0);
    add_item(32'h0000_0009, 1'b1, 1'b0);
    add_item(32'h0000_0009, 1'b0, 1'b0);
    add_item(32'hA5A5_A5A5, 1'b1, 1'b1);
    add_item(32'h0000_0010, 1'b1, 1'b0);
    add_item(32'h0000_0003, 1'b1, 1'b0);
    add_item(32'h0000_0010, 1'b0, 1'b1);
    add_item(32'h0000_0001, 1'b0, 1'b0);
    add_item(32'h0000_0002, 1'b0, 1'b1);
    wait_drained();

    // More positives arrive than P claims.
    write_positive_total(CNT_W'(2));
    add_item(32'h8000_0000, 1'b0, 1'b0);
    add_item(32'h8000_0000, 1'b1, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b1, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b1, 1'b1);
    wait_drained();

    write_positive_total(CNT_W'(1));
    add_item(32'h1234_5678, 1'b1, 1'b0);
    add_item(32'h1234_5679, 1'b0, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 7 : 0;
      for (int part = 0; part < 3; part++) begin
        case ($urandom_range(0, 4))
          0: p_value = '0;
          1: p_value = CNT_W'(65536);
          2: p_value = CNT_W'($urandom_range(1, 8));
          3: p_value = CNT_W'($urandom_range(0, 65536));
          default: p_value = CNT_W'($urandom_range(0, 40));
        endcase
        write_positive_total(p_value);
        part_start = items_queued;
        // Short runs behind a long result hold-off back up into the input.
        if (phase == 2 && part == 0) begin
          for (int r = 0; r < 60; r++) add_random_run($urandom_range(1, 3), 1'b0);
          hold_go = !hold_go;
        end
        while (items_queued - part_start < PART_ITEMS) begin
          add_random_run(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(1, 12),
                         $urandom_range(0, 9) == 0);
        end
        wait_drained();
      end
    end

    $display("Scanned %0d requests and checked %0d results, %0d with a scoring group.",
             items_taken, results_checked, results_found);
    $display("Input was held off for %0d cycles while results backed up.",
             input_stall_cycles);
    if (errors == 0) begin
      $display("PASS best_f1_threshold_scan");
    end else begin
      $display("FAIL best_f1_threshold_scan");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still awaited.", expected_best.size());
    $display("FAIL best_f1_threshold_scan");
    $finish;
  end

endmodule
